[rtl/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg - shared definitions for the midpoint circle rasterizer
// Command codes, recurrence constants, per-job control flags and result sequencing.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // Command codes carried in the command field of a request.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Decision variable constants of the midpoint recurrence.
    localparam int DEC_INIT    = 3;
    localparam int STEP_ACROSS = 6;
    localparam int STEP_DIAG   = 10;

    // Result sequencing: eight octant points, four spans, two diameters.
    localparam int NUM_POINTS = 8;
    localparam int NUM_SPANS  = 4;
    localparam int NUM_DIAMS  = 2;
    localparam int RES_IDX_W  = 4;

    // Control flags that travel with each job from the front to the back.
    typedef struct packed {
        logic spans;
        logic diams;
        logic done;
    } job_ctrl_t;

endpackage

[rtl/mcr_cmd_if.sv]
// ----------------------------------------------------------------------------
// mcr_cmd_if - command channel
// Valid/ready channel carrying start and step commands.
// ----------------------------------------------------------------------------
interface mcr_cmd_if #(
    parameter int COORD_BITS  = 16,
    parameter int RADIUS_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0] radius;

    modport source (
        output valid, command, center_x, center_y, radius,
        input  ready
    );

    modport sink (
        input  valid, command, center_x, center_y, radius,
        output ready
    );
endinterface

[rtl/mcr_res_if.sv]
// ----------------------------------------------------------------------------
// mcr_res_if - result channel
// Valid/ready channel carrying one point or segment per request.
// ----------------------------------------------------------------------------
interface mcr_res_if #(
    parameter int COORD_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [COORD_BITS:0] x_start;
    logic signed [COORD_BITS:0] y_start;
    logic signed [COORD_BITS:0] x_end;
    logic signed [COORD_BITS:0] y_end;
    logic                       is_segment;
    logic                       last_of_run;
    logic                       circle_done;

    modport source (
        output valid, x_start, y_start, x_end, y_end, is_segment, last_of_run,
               circle_done,
        input  ready
    );

    modport sink (
        input  valid, x_start, y_start, x_end, y_end, is_segment, last_of_run,
               circle_done,
        output ready
    );
endinterface

[rtl/mcr_cfg_if.sv]
// ----------------------------------------------------------------------------
// mcr_cfg_if - configuration write channel
// Valid/ready channel carrying the fill mode register value.
// ----------------------------------------------------------------------------
interface mcr_cfg_if;
    logic valid;
    logic ready;
    logic fill_mode;

    modport source (
        output valid, fill_mode,
        input  ready
    );

    modport sink (
        input  valid, fill_mode,
        output ready
    );
endinterface

[rtl/mcr_front.sv]
// ----------------------------------------------------------------------------
// mcr_front - command front end
// Runs the midpoint recurrence, queueing a job per start or active step.
// ----------------------------------------------------------------------------
module mcr_front #(
    parameter int COORD_BITS  = 16,
    parameter int RADIUS_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mcr_cmd_if.sink                       cmd,
    mcr_cfg_if.sink                       cfg,
    input  logic                          q_full,
    output logic                          push,
    output mcr_pkg::job_ctrl_t            job_ctrl,
    output logic signed [COORD_BITS-1:0]  job_cx,
    output logic signed [COORD_BITS-1:0]  job_cy,
    output logic        [RADIUS_BITS-1:0] job_x,
    output logic        [RADIUS_BITS-1:0] job_y,
    output logic        [RADIUS_BITS-1:0] job_r
);
    import mcr_pkg::*;

    localparam int DEC_W = RADIUS_BITS + 4;

    logic                          fill_mode_reg;
    logic                          busy_reg;
    logic        [RADIUS_BITS-1:0] offset_x_reg;
    logic        [RADIUS_BITS-1:0] offset_y_reg;
    logic signed [DEC_W-1:0]       decision_reg;
    logic signed [COORD_BITS-1:0]  cx_reg;
    logic signed [COORD_BITS-1:0]  cy_reg;
    logic        [RADIUS_BITS-1:0] radius_reg;

    logic                          accept;
    logic                          is_start;
    logic signed [DEC_W-1:0]       x_ext;
    logic signed [DEC_W-1:0]       y_ext;
    logic signed [DEC_W-1:0]       r_ext;
    logic signed [DEC_W-1:0]       dec_across;
    logic signed [DEC_W-1:0]       dec_diag;
    logic        [RADIUS_BITS-1:0] x_next;
    logic        [RADIUS_BITS-1:0] y_next;
    logic signed [DEC_W-1:0]       decision_next;
    logic                          done_next;

    assign cmd.ready = !q_full;
    assign cfg.ready = 1'b1;

    assign accept   = cmd.valid && cmd.ready;
    assign is_start = (cmd.command == CMD_START);

    assign x_ext = DEC_W'(offset_x_reg);
    assign y_ext = DEC_W'(offset_y_reg);
    assign r_ext = DEC_W'(cmd.radius);

    assign dec_across = decision_reg + (x_ext <<< 2) + DEC_W'(STEP_ACROSS);
    assign dec_diag   = decision_reg + ((x_ext - y_ext) <<< 2) + DEC_W'(STEP_DIAG);

    always_comb
    begin
        if (is_start)
        begin
            x_next        = '0;
            y_next        = cmd.radius;
            decision_next = DEC_W'(DEC_INIT) - (r_ext <<< 1);
        end
        else
        begin
            x_next = offset_x_reg + RADIUS_BITS'(1);
            // A negative decision keeps y; otherwise the step moves diagonally.
            if (decision_reg[DEC_W-1])
            begin
                y_next        = offset_y_reg;
                decision_next = dec_across;
            end
            else
            begin
                y_next        = offset_y_reg - RADIUS_BITS'(1);
                decision_next = dec_diag;
            end
        end
    end

    assign done_next = (x_next >= y_next);

    // A step with no circle active is taken and dropped without a job.
    assign push = accept && (is_start || busy_reg);

    assign job_ctrl.spans = !is_start && fill_mode_reg;
    assign job_ctrl.diams = fill_mode_reg && done_next;
    assign job_ctrl.done  = done_next;
    assign job_cx = is_start ? cmd.center_x : cx_reg;
    assign job_cy = is_start ? cmd.center_y : cy_reg;
    assign job_r  = is_start ? cmd.radius : radius_reg;
    assign job_x  = x_next;
    assign job_y  = y_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_mode_reg <= 1'b0;
            busy_reg      <= 1'b0;
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
            decision_reg  <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            radius_reg    <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                fill_mode_reg <= cfg.fill_mode;
            end
            if (push)
            begin
                busy_reg     <= !done_next;
                offset_x_reg <= x_next;
                offset_y_reg <= y_next;
                decision_reg <= decision_next;
                if (is_start)
                begin
                    cx_reg     <= cmd.center_x;
                    cy_reg     <= cmd.center_y;
                    radius_reg <= cmd.radius;
                end
            end
        end
    end

    // An active circle always has its x offset below its y offset.
    a_busy_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (offset_x_reg < offset_y_reg))
        else $error("active circle with x offset not below y offset");

endmodule

[rtl/mcr_queue.sv]
// ----------------------------------------------------------------------------
// mcr_queue - two-entry job queue
// Decouples the command front end from the result sequencer.
// ----------------------------------------------------------------------------
module mcr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] entries_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("job popped from an empty queue");

endmodule

[rtl/mcr_back.sv]
// ----------------------------------------------------------------------------
// mcr_back - result sequencer
// Walks one job's points, spans and diameters, one result per unstalled cycle.
// ----------------------------------------------------------------------------
module mcr_back #(
    parameter int COORD_BITS  = 16,
    parameter int RADIUS_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  mcr_pkg::job_ctrl_t            job_ctrl,
    input  logic signed [COORD_BITS-1:0]  job_cx,
    input  logic signed [COORD_BITS-1:0]  job_cy,
    input  logic        [RADIUS_BITS-1:0] job_x,
    input  logic        [RADIUS_BITS-1:0] job_y,
    input  logic        [RADIUS_BITS-1:0] job_r,
    output logic                          pop,
    mcr_res_if.source                     res
);
    import mcr_pkg::*;

    localparam int OUT_W = COORD_BITS + 1;
    localparam int SUM_W = (RADIUS_BITS > OUT_W) ? RADIUS_BITS : OUT_W;

    typedef logic signed [OUT_W-1:0] coord_t;

    // Coordinates wrap to the output width, so only the low bits matter.
    function automatic coord_t offset_coord(
        input logic signed [COORD_BITS-1:0]  c,
        input logic        [RADIUS_BITS-1:0] o,
        input logic                          neg
    );
        logic signed [SUM_W-1:0] cs;
        logic signed [SUM_W-1:0] os;
        logic signed [SUM_W-1:0] s;
        cs = SUM_W'(c);
        os = SUM_W'(o);
        s  = neg ? (cs - os) : (cs + os);
        return s[OUT_W-1:0];
    endfunction

    logic                 out_valid_reg;
    coord_t               x_start_reg;
    coord_t               y_start_reg;
    coord_t               x_end_reg;
    coord_t               y_end_reg;
    logic                 is_segment_reg;
    logic                 last_of_run_reg;
    logic                 circle_done_reg;
    logic [RES_IDX_W-1:0] idx_reg;
    logic [RES_IDX_W-1:0] idx_next;

    logic [RES_IDX_W-1:0] last_idx;
    logic                 at_last;
    logic                 load;

    coord_t cxpx, cxmx, cxpy, cxmy, cypx, cymx, cypy, cymy;
    coord_t cxpr, cxmr, cypr, cymr, cx0, cy0;
    coord_t xs_sel, ys_sel, xe_sel, ye_sel;
    logic   seg_sel;

    assign cxpx = offset_coord(job_cx, job_x, 1'b0);
    assign cxmx = offset_coord(job_cx, job_x, 1'b1);
    assign cxpy = offset_coord(job_cx, job_y, 1'b0);
    assign cxmy = offset_coord(job_cx, job_y, 1'b1);
    assign cypx = offset_coord(job_cy, job_x, 1'b0);
    assign cymx = offset_coord(job_cy, job_x, 1'b1);
    assign cypy = offset_coord(job_cy, job_y, 1'b0);
    assign cymy = offset_coord(job_cy, job_y, 1'b1);
    assign cxpr = offset_coord(job_cx, job_r, 1'b0);
    assign cxmr = offset_coord(job_cx, job_r, 1'b1);
    assign cypr = offset_coord(job_cy, job_r, 1'b0);
    assign cymr = offset_coord(job_cy, job_r, 1'b1);
    assign cx0  = OUT_W'(job_cx);
    assign cy0  = OUT_W'(job_cy);

    assign last_idx = RES_IDX_W'(NUM_POINTS - 1)
                    + (job_ctrl.spans ? RES_IDX_W'(NUM_SPANS) : '0)
                    + (job_ctrl.diams ? RES_IDX_W'(NUM_DIAMS) : '0);
    assign at_last  = (idx_reg == last_idx);
    assign load     = job_valid && (!out_valid_reg || res.ready);
    assign pop      = load && at_last;
    assign idx_next = at_last ? '0 : (idx_reg + RES_IDX_W'(1));

    // Diameters always sit on an even/odd index pair, spans on four
    // consecutive indices starting right after the points.
    always_comb
    begin
        xs_sel  = cx0;
        ys_sel  = cy0;
        xe_sel  = cx0;
        ye_sel  = cy0;
        seg_sel = 1'b1;
        priority if (idx_reg < RES_IDX_W'(NUM_POINTS))
        begin
            seg_sel = 1'b0;
            unique case (idx_reg[2:0])
                3'd0:    begin xs_sel = cxpx; ys_sel = cypy; end
                3'd1:    begin xs_sel = cxmx; ys_sel = cypy; end
                3'd2:    begin xs_sel = cxpx; ys_sel = cymy; end
                3'd3:    begin xs_sel = cxmx; ys_sel = cymy; end
                3'd4:    begin xs_sel = cxpy; ys_sel = cypx; end
                3'd5:    begin xs_sel = cxmy; ys_sel = cypx; end
                3'd6:    begin xs_sel = cxpy; ys_sel = cymx; end
                default: begin xs_sel = cxmy; ys_sel = cymx; end
            endcase
            xe_sel = xs_sel;
            ye_sel = ys_sel;
        end
        else if (job_ctrl.spans && (idx_reg < RES_IDX_W'(NUM_POINTS + NUM_SPANS)))
        begin
            unique case (idx_reg[1:0])
                2'd0:    begin xs_sel = cxmx; xe_sel = cxpx; ys_sel = cymy; end
                2'd1:    begin xs_sel = cxmx; xe_sel = cxpx; ys_sel = cypy; end
                2'd2:    begin xs_sel = cxmy; xe_sel = cxpy; ys_sel = cymx; end
                default: begin xs_sel = cxmy; xe_sel = cxpy; ys_sel = cypx; end
            endcase
            ye_sel = ys_sel;
        end
        else
        begin
            if (!idx_reg[0])
            begin
                xs_sel = cxmr;
                xe_sel = cxpr;
            end
            else
            begin
                ys_sel = cymr;
                ye_sel = cypr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_start_reg     <= xs_sel;
            y_start_reg     <= ys_sel;
            x_end_reg       <= xe_sel;
            y_end_reg       <= ye_sel;
            is_segment_reg  <= seg_sel;
            last_of_run_reg <= at_last;
            circle_done_reg <= job_ctrl.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.x_start     = x_start_reg;
    assign res.y_start     = y_start_reg;
    assign res.x_end       = x_end_reg;
    assign res.y_end       = y_end_reg;
    assign res.is_segment  = is_segment_reg;
    assign res.last_of_run = last_of_run_reg;
    assign res.circle_done = circle_done_reg;

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> (idx_reg <= last_idx))
        else $error("result index ran past the end of the job");

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid |-> (idx_reg == '0))
        else $error("result index not cleared between jobs");

endmodule

[rtl/midpoint_circle_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer - midpoint circle rasterizer, eight-way symmetry
// Turns start and step commands into octant points, fill spans and diameters.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                          Request
//  -------  ---  -----------------------------------------------  -------------
//  cmd      in   command, center_x, center_y, radius              one command
//  res      out  x_start, y_start, x_end, y_end, is_segment,      one point or
//                last_of_run, circle_done                         segment
//  cfg      in   fill_mode                                        register write
//
//  A command that produces output gives 8 results on the result channel in
//  outline mode, 8 to 14 in fill mode; the result sequencer emits one result
//  per cycle while the result channel is ready and sets the rate. The front
//  end holds up to two commands ahead in its queue and accepts a command
//  whenever the queue is not full. A step with no circle active is accepted and
//  produces nothing. Reset clears control state, not queue or result data; a
//  stalled result channel backs up into the queue, then the command channel.
//
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS  = 16,
    parameter int RADIUS_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    mcr_cmd_if.sink    cmd,
    mcr_res_if.source  res,
    mcr_cfg_if.sink    cfg
);
    import mcr_pkg::*;

    localparam int CTRL_W = $bits(job_ctrl_t);
    localparam int JOB_W  = CTRL_W + 2 * COORD_BITS + 3 * RADIUS_BITS;

    logic                          push;
    logic                          q_full;
    logic                          pop;
    logic                          job_valid;
    logic [JOB_W-1:0]              push_data;
    logic [JOB_W-1:0]              pop_data;

    job_ctrl_t                     f_ctrl;
    logic signed [COORD_BITS-1:0]  f_cx;
    logic signed [COORD_BITS-1:0]  f_cy;
    logic        [RADIUS_BITS-1:0] f_x;
    logic        [RADIUS_BITS-1:0] f_y;
    logic        [RADIUS_BITS-1:0] f_r;

    job_ctrl_t                     b_ctrl;
    logic signed [COORD_BITS-1:0]  b_cx;
    logic signed [COORD_BITS-1:0]  b_cy;
    logic        [RADIUS_BITS-1:0] b_x;
    logic        [RADIUS_BITS-1:0] b_y;
    logic        [RADIUS_BITS-1:0] b_r;

    mcr_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .job_ctrl (f_ctrl),
        .job_cx   (f_cx),
        .job_cy   (f_cy),
        .job_x    (f_x),
        .job_y    (f_y),
        .job_r    (f_r)
    );

    assign push_data = {f_ctrl, f_cx, f_cy, f_x, f_y, f_r};

    mcr_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (job_valid),
        .pop_data  (pop_data)
    );

    assign {b_ctrl, b_cx, b_cy, b_x, b_y, b_r} = pop_data;

    mcr_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ctrl  (b_ctrl),
        .job_cx    (b_cx),
        .job_cy    (b_cy),
        .job_x     (b_x),
        .job_y     (b_y),
        .job_r     (b_r),
        .pop       (pop),
        .res       (res)
    );

endmodule
